// ===== design/fsp_pkg.sv =====
// Package for the fair share priority block: widths, register indexes,
// reset values and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
package fsp_pkg;
	localparam int unsigned NumSlotsDefault = 64;
	localparam logic [1:0] REG_CYCLES_PER_MS = 2'd0;
	localparam logic [1:0] REG_DECAY_WINDOW  = 2'd1;
	localparam logic [1:0] REG_PRIORITY_BASE = 2'd2;
	localparam logic [31:0] CPM_RESET    = 32'd0;
	localparam logic [15:0] WINDOW_RESET = 16'd500;
	localparam logic [10:0] BASE_RESET   = 11'd100;
	localparam logic [63:0] MIN_INTERVAL = 64'd10;
	localparam logic [63:0] PERMILLE     = 64'd1000;
	localparam logic [17:0] PRIO_MAX     = 18'h3FFFF;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_READ  = 14'b00000000000010,
		ST_CHECK = 14'b00000000000100,
		ST_MUL1  = 14'b00000000001000,
		ST_DIV1  = 14'b00000000010000,
		ST_MIX   = 14'b00000000100000,
		ST_DIV2  = 14'b00000001000000,
		ST_WRITE = 14'b00000010000000,
		ST_PRIO  = 14'b00000100000000,
		ST_DIV3  = 14'b00001000000000,
		ST_DIV4  = 14'b00010000000000,
		ST_OUT   = 14'b00100000000000,
		ST_MULLO = 14'b01000000000000,
		ST_MULHI = 14'b10000000000000
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;
endpackage

// ===== design/fsp_div.sv =====
// Iterative 64-bit unsigned divider, one quotient bit per cycle.
// Depends on fsp_pkg. A zero divisor yields a quotient of zero.
`timescale 1ns / 1ps
module fsp_div
	import fsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	output logic        done,
	output logic [63:0] quotient
);
	logic [63:0] rem_q, quo_q, dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q, zero_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};
	assign quotient = zero_q ? 64'd0 : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= 64'd0;
			quo_q  <= req.dividend;
			dvs_q  <= req.divisor;
			zero_q <= (req.divisor == 64'd0);
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

// ===== design/fair_share_priority.sv =====
// Top level of the fair share priority block: configuration registers,
// per-slot state memory and the sequencer. Depends on fsp_pkg and fsp_div.
`timescale 1ns / 1ps
// One item at a time. An accepted beat reads its slot from a synchronous
// memory with a registered read holding the decayed average, last update
// time and last cycle count, then runs up to four 64-bit divisions on a
// single shared shift-subtract divider: the run fraction, the mixed
// average, fair share and the final priority. The elapsed-cycles product
// is built low half then high half on one 32 by 32 multiplier. The state
// memory is cleared by a pass over every slot after reset, during which
// no beat is accepted. A result waits in the output register while
// m_tready stays low, and no new beat is taken until it leaves.
module fair_share_priority
	import fsp_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = NumSlotsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot[5:0], now_ms[69:6], cpu_cycles[133:70], weight[141:134],
	// runnable_count[157:142], zero fill to 160
	input  logic [159:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// priority_res[17:0], usage_permille[27:18], average_updated[28], zero fill
	output logic [31:0] m_tdata
);
	localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [31:0] cpm_q;
	logic [15:0] window_q;
	logic [10:0] base_q;

	// state memory: average, last time, last cycles
	logic [137:0] mem [NUM_SLOTS];
	logic [137:0] rd_s1;
	logic         we;
	logic [AW-1:0] wa, ra;
	logic [137:0] wd;

	logic [AW:0]  clr_q;
	logic         clearing;
	state_t       st_q;

	logic [AW-1:0] slot_q;
	logic [63:0] now_q, cyc_q, elapsed_q, used_q, prod_q, mix_q;
	logic [7:0]  weight_q;
	logic [15:0] run_q;
	logic [9:0]  avg_q;
	logic        upd_q;
	logic [18:0] cap_q;
	logic [15:0] span_q, win_q;
	logic [31:0] out_q;
	logic        ovalid_q;

	div_req_t    dreq;
	logic        ddone;
	logic [63:0] dquo;
	logic [AW-1:0] slot_lut [64];
	logic [AW-1:0] slot_in;
	logic [63:0] elapsed_c;
	logic [31:0] cpm_eff, mul_a;
	logic [63:0] mul_p;
	logic [9:0]  frac_c;

	fsp_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quotient(dquo));

	// fold the slot field onto the table size
	for (genvar gi = 0; gi < 64; gi++) begin : g_slot_wrap
		assign slot_lut[gi] = AW'(gi % NUM_SLOTS);
	end

	assign clearing = (clr_q < (AW+1)'(NUM_SLOTS));
	assign s_tready = (st_q == ST_IDLE) && !clearing && !ovalid_q;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = out_q;
	assign slot_in  = slot_lut[s_tdata[5:0]];

	assign elapsed_c = now_q - rd_s1[127:64];
	assign cpm_eff   = (cpm_q == 32'd0) ? 32'd1 : cpm_q;
	// low half first, then the high half shifted up by 32
	assign mul_a     = (st_q == ST_MULHI) ? elapsed_q[63:32] : elapsed_q[31:0];
	assign mul_p     = {32'd0, mul_a} * {32'd0, cpm_eff};
	assign frac_c    = (dquo > PERMILLE) ? PERMILLE[9:0] : dquo[9:0];

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpm_q    <= CPM_RESET;
			window_q <= WINDOW_RESET;
			base_q   <= BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CYCLES_PER_MS: cpm_q    <= cfg_data;
				REG_DECAY_WINDOW:  window_q <= cfg_data[15:0];
				REG_PRIORITY_BASE: base_q   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// memory port: write and registered read
	assign ra = slot_q;
	always_comb begin
		we = clearing || (st_q == ST_WRITE);
		wa = clearing ? clr_q[AW-1:0] : slot_q;
		wd = clearing ? 138'd0 : {mix_q[9:0], now_q, cyc_q};
	end
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_s1 <= mem[ra];
	end

	// divider requests
	always_comb begin
		dreq = '0;
		case (st_q)
			ST_MUL1: begin
				dreq.start    = 1'b1;
				dreq.dividend = used_q * PERMILLE;
				dreq.divisor  = prod_q;
			end
			ST_MIX: begin
				dreq.start    = 1'b1;
				dreq.dividend = mix_q;
				dreq.divisor  = 64'(span_q);
			end
			ST_PRIO: begin
				dreq.start    = 1'b1;
				dreq.dividend = PERMILLE;
				dreq.divisor  = (run_q == 16'd0) ? 64'd1 : 64'(run_q);
			end
			ST_DIV4: begin
				dreq.start    = !ddone ? 1'b0 : 1'b0;
			end
			default: ;
		endcase
		// fair share is at most 1000, so ten bits carry it
		if (st_q == ST_DIV3 && ddone) begin
			dreq.start    = 1'b1;
			dreq.dividend = 64'(dquo[9:0]) * 64'(cap_q);
			dreq.divisor  = (avg_q == 10'd0) ? 64'd1 : 64'(avg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			if (ovalid_q && m_tready) ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE:  if (s_tvalid && s_tready) st_q <= ST_READ;
				ST_READ:  st_q <= ST_CHECK;
				ST_CHECK: st_q <= (elapsed_c >= MIN_INTERVAL) ? ST_MULLO : ST_PRIO;
				ST_MULLO: st_q <= ST_MULHI;
				ST_MULHI: st_q <= ST_MUL1;
				ST_MUL1:  st_q <= ST_DIV1;
				ST_DIV1:  if (ddone) st_q <= ST_MIX;
				ST_MIX:   st_q <= ST_DIV2;
				ST_DIV2:  if (ddone) st_q <= ST_WRITE;
				ST_WRITE: st_q <= ST_PRIO;
				ST_PRIO:  st_q <= ST_DIV3;
				ST_DIV3:  if (ddone) st_q <= ST_DIV4;
				ST_DIV4:  if (ddone) st_q <= ST_OUT;
				ST_OUT: begin
					ovalid_q <= 1'b1;
					st_q     <= ST_IDLE;
				end
				default:  st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				slot_q   <= slot_in;
				now_q    <= s_tdata[69:6];
				cyc_q    <= s_tdata[133:70];
				weight_q <= s_tdata[141:134];
				run_q    <= s_tdata[157:142];
				span_q   <= (window_q == 16'd0) ? 16'd1 : window_q;
			end
			ST_READ: ;
			ST_CHECK: begin
				// hold stored average, take deltas
				avg_q     <= rd_s1[137:128];
				elapsed_q <= elapsed_c;
				used_q    <= cyc_q - rd_s1[63:0];
				upd_q     <= elapsed_c >= MIN_INTERVAL;
				mix_q     <= {54'd0, rd_s1[137:128]};
				win_q     <= (elapsed_c > 64'(span_q)) ? span_q : elapsed_c[15:0];
			end
			// elapsed*cpm modulo 2^64, low then high half
			ST_MULLO: prod_q <= mul_p;
			ST_MULHI: prod_q <= prod_q + {mul_p[31:0], 32'd0};
			ST_MUL1: ;
			ST_DIV1: if (ddone) begin
				mix_q <= 64'(avg_q) * 64'(span_q - win_q) + 64'(frac_c) * 64'(win_q);
			end
			ST_MIX: ;
			ST_DIV2: if (ddone) mix_q <= {54'd0, dquo[9:0]};
			ST_WRITE: avg_q <= mix_q[9:0];
			ST_PRIO: cap_q <= 19'(weight_q * base_q);
			ST_DIV3: ;
			ST_DIV4: if (ddone) begin
				out_q <= {3'd0, upd_q, avg_q,
					(dquo > 64'(cap_q)) ? ((cap_q > 19'(PRIO_MAX)) ? PRIO_MAX : cap_q[17:0])
					: ((dquo > 64'(PRIO_MAX)) ? PRIO_MAX : dquo[17:0])};
			end
			default: ;
		endcase
	end
endmodule

// ===== dv/fair_share_priority_tb.sv =====
// Self-checking bench for fair_share_priority: drives task-usage beats,
// predicts priority and decayed average per slot, compares each result beat.
// Depends on fsp_pkg and the fair_share_priority RTL.
`timescale 1ns / 1ps
module fair_share_priority_tb
	import fsp_pkg::*;
;
	localparam int WatchdogLimit = 20000;

	// packed from the top bit down: flag, average, priority
	typedef struct packed {
		logic        average_updated;
		logic [9:0]  usage_permille;
		logic [17:0] priority_res;
	} prio_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = REG_CYCLES_PER_MS;
	logic [31:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;

	// Predictor copy of configuration and per-slot state.
	logic [31:0] cpm_reg;
	logic [15:0] window_reg;
	logic [10:0] base_reg;
	logic [9:0]  slot_avg [64];
	logic [63:0] slot_time [64];
	logic [63:0] slot_cycles [64];

	prio_result_t expected_results[$];
	int  error_count = 0;
	int  idle_cycles = 0;
	bit  stall_enable = 1'b1;

	fair_share_priority u_top (.*);

	always #6 clk = ~clk;

	// Pick a gap length: mostly zero or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// Compute one priority result and advance the slot state.
	function automatic prio_result_t predict_priority(logic [5:0] slot, logic [63:0] now,
			logic [63:0] cyc, logic [7:0] weight, logic [15:0] runnable);
		prio_result_t res;
		logic [63:0] elapsed, span, win, cpm, denom, frac, fair, avg, cap, r;
		elapsed = now - slot_time[slot];
		res.average_updated = 1'b0;
		if (elapsed >= 64'd10) begin
			span = (window_reg == 0) ? 64'd1 : 64'(window_reg);
			win = (elapsed > span) ? span : elapsed;
			cpm = (cpm_reg == 0) ? 64'd1 : 64'(cpm_reg);
			denom = elapsed * cpm;
			frac = (denom == 0) ? 64'd0 : ((cyc - slot_cycles[slot]) * 64'd1000) / denom;
			if (frac > 64'd1000) frac = 64'd1000;
			slot_avg[slot] = 10'((64'(slot_avg[slot]) * (span - win) + frac * win) / span);
			slot_time[slot] = now;
			slot_cycles[slot] = cyc;
			res.average_updated = 1'b1;
		end
		fair = 64'd1000 / ((runnable == 0) ? 64'd1 : 64'(runnable));
		avg = (slot_avg[slot] == 0) ? 64'd1 : 64'(slot_avg[slot]);
		cap = 64'(weight) * 64'(base_reg);
		r = (fair * cap) / avg;
		if (r > cap) r = cap;
		if (r > 64'h3FFFF) r = 64'h3FFFF;
		res.priority_res = r[17:0];
		res.usage_permille = slot_avg[slot];
		return res;
	endfunction

	// Send one beat after a random gap; record its expectation at acceptance.
	task automatic send_usage(logic [5:0] slot, logic [63:0] now, logic [63:0] cyc,
			logic [7:0] weight, logic [15:0] runnable, bit no_gap = 1'b0);
		int g;
		g = no_gap ? 0 : gap_len();
		repeat (g) @(negedge clk);
		s_tdata = {2'b00, runnable, weight, cyc, now, slot};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(predict_priority(slot, now, cyc, weight, runnable));
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic drain();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// Write one register; the block must be idle.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CYCLES_PER_MS: cpm_reg = value;
			REG_DECAY_WINDOW:  window_reg = value[15:0];
			REG_PRIORITY_BASE: base_reg = value[10:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Receiver: random stalls on m_tready.
	initial begin
		int g;
		forever begin
			@(negedge clk);
			g = gap_len();
			if (stall_enable && $urandom_range(0, 3) == 0 && g != 0) begin
				m_tready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Result checker, field by field against the oldest expectation.
	always @(posedge clk) begin
		prio_result_t got, exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[28:0];
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: %h", m_tdata);
				error_count++;
			end else begin
				exp_res = expected_results.pop_front();
				if (got.priority_res !== exp_res.priority_res) begin
					$error("priority_res expected %0d got %0d", exp_res.priority_res,
						got.priority_res);
					error_count++;
				end
				if (got.usage_permille !== exp_res.usage_permille) begin
					$error("usage_permille expected %0d got %0d", exp_res.usage_permille,
						got.usage_permille);
					error_count++;
				end
				if (got.average_updated !== exp_res.average_updated) begin
					$error("average_updated expected %0d got %0d", exp_res.average_updated,
						got.average_updated);
					error_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no beat accepted on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic test_directed();
		// Reset configuration, first visits, extremes of every field.
		send_usage(6'd0, 64'd0, 64'd0, 8'd0, 16'd0);
		send_usage(6'd0, 64'd9, 64'd5, 8'd255, 16'd1);
		send_usage(6'd0, 64'd10, 64'd10, 8'd255, 16'd0);
		send_usage(6'd63, '1, '1, 8'd255, 16'hFFFF);
		send_usage(6'd63, 64'd20, 64'd0, 8'd1, 16'd3);
		send_usage(6'd1, 64'd1000, 64'd500, 8'd128, 16'd2);
		send_usage(6'd1, 64'd1003, 64'd900, 8'd128, 16'd2);
		send_usage(6'd2, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 8'd7, 16'd1000);
		send_usage(6'd2, 64'h8000_0000_0000_1000, 64'h1, 8'd200, 16'd1001);
		drain();
		// Zero window acts as one; wrapping cycle product; oversized base saturates.
		write_reg(REG_DECAY_WINDOW, 32'd0);
		write_reg(REG_CYCLES_PER_MS, 32'hFFFF_FFFF);
		write_reg(REG_PRIORITY_BASE, 32'h7FF);
		send_usage(6'd3, 64'h1_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 16'd1);
		send_usage(6'd3, 64'h2_0000_0000, 64'h5555_5555_5555_5555, 8'd255, 16'd1);
		send_usage(6'd4, 64'd50, 64'd40, 8'd255, 16'd0);
		send_usage(6'd4, 64'd52, 64'd40, 8'd255, 16'd0);
		drain();
		write_reg(REG_DECAY_WINDOW, 32'hFFFF);
		write_reg(REG_CYCLES_PER_MS, 32'd1);
		write_reg(REG_PRIORITY_BASE, 32'd1024);
		send_usage(6'd5, 64'd100, 64'd100, 8'd255, 16'd1);
		send_usage(6'd5, 64'd70000, 64'd5000, 8'd255, 16'd1);
		send_usage(6'd5, 64'd69990, 64'd4000, 8'd33, 16'd4);
		drain();
	endtask

	// Random traffic: mostly plausible advancing timelines per slot.
	task automatic test_random(int count);
		logic [63:0] now, cyc, step;
		logic [5:0] slot;
		int mode;
		for (int i = 0; i < count; i++) begin
			slot = 6'($urandom_range(0, 63));
			mode = $urandom_range(0, 9);
			if (mode < 7) begin
				step = (mode < 2) ? 64'($urandom_range(0, 15)) : 64'($urandom_range(5, 2000));
				now = slot_time[slot] + step;
				cyc = slot_cycles[slot] + step * 64'(cpm_reg) * 64'($urandom_range(0, 1100))
					/ 64'd1000;
			end else begin
				now = {$urandom, $urandom};
				cyc = {$urandom, $urandom};
			end
			send_usage(slot, now, cyc, 8'($urandom), ($urandom_range(0, 3) == 0) ?
				16'($urandom) : 16'($urandom_range(0, 20)), i % 200 < 40);
		end
	endtask

	task automatic test_config_sweep();
		write_reg(REG_CYCLES_PER_MS, 32'd0);
		write_reg(REG_DECAY_WINDOW, 32'd1);
		write_reg(REG_PRIORITY_BASE, 32'd1);
		test_random(300);
		drain();
		write_reg(REG_CYCLES_PER_MS, 32'd1000);
		write_reg(REG_DECAY_WINDOW, 32'd500);
		write_reg(REG_PRIORITY_BASE, 32'd100);
		test_random(600);
		// Hold the sender until every result is back, then keep going.
		drain();
		stall_enable = 1'b0;
		test_random(200);
		stall_enable = 1'b1;
		drain();
		write_reg(REG_CYCLES_PER_MS, $urandom);
		write_reg(REG_DECAY_WINDOW, 32'($urandom_range(1, 65535)));
		write_reg(REG_PRIORITY_BASE, 32'($urandom_range(1, 2047)));
		test_random(700);
		drain();
	endtask

	initial begin
		cpm_reg = CPM_RESET;
		window_reg = WINDOW_RESET;
		base_reg = BASE_RESET;
		for (int i = 0; i < 64; i++) begin
			slot_avg[i] = '0;
			slot_time[i] = '0;
			slot_cycles[i] = '0;
		end
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_config_sweep();
		if (error_count == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
